// ===== rtl/apvt_pkg.sv =====
// Shared widths, types and codes for the affine point/vector transform.
package apvt_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int MAT_DIM    = 4;
    localparam int OUT_ROWS   = 3;
    localparam int IDX_W      = 2;

    localparam int PROD_W = 2 * DATA_WIDTH;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;

    // Input tdata layout, lowest bit first
    localparam int ROW_LSB   = 0;
    localparam int COL_LSB   = ROW_LSB + IDX_W;
    localparam int ENTRY_LSB = COL_LSB + IDX_W;
    localparam int X_LSB     = ENTRY_LSB + DATA_WIDTH;
    localparam int Y_LSB     = X_LSB + DATA_WIDTH;
    localparam int Z_LSB     = Y_LSB + DATA_WIDTH;
    localparam int IN_BITS   = Z_LSB + DATA_WIDTH;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_ROWS * DATA_WIDTH + 7) / 8) * 8;

    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TUSER_W = 2;
    localparam int TU_OP       = 0;
    localparam int TU_IS_POINT = 1;
    localparam int TU_RES_PT   = 0;
    localparam int TU_OVF      = 1;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } t_op;

    typedef logic signed [DATA_WIDTH-1:0] t_word;
    typedef logic signed [PROD_W-1:0]     t_prod;
    typedef logic signed [PAIR_W-1:0]     t_pair;
    typedef logic signed [SUM_W-1:0]      t_sum;
    typedef logic        [IDX_W-1:0]      t_idx;

    typedef t_word t_row_vec [MAT_DIM];
    typedef t_row_vec t_matrix [OUT_ROWS];

    // Per-stage load enables shared by every row lane
    typedef struct packed {
        logic en_mul;
        logic en_pair;
        logic en_sum;
    } t_stage_en;

endpackage

// ===== rtl/apvt_matrix.sv =====
// Matrix entry storage; only the rows that feed results are kept.
module apvt_matrix (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  apvt_pkg::t_idx        i_row,
    input  apvt_pkg::t_idx        i_col,
    input  apvt_pkg::t_word       i_value,
    output apvt_pkg::t_matrix     o_rows
);

    apvt_pkg::t_matrix r_mat;
    logic              n_row_kept;

    // Fourth row is never read: drop its writes
    assign n_row_kept = (i_row < apvt_pkg::IDX_W'(apvt_pkg::OUT_ROWS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < apvt_pkg::OUT_ROWS; r++) begin
                for (int c = 0; c < apvt_pkg::MAT_DIM; c++) begin
                    r_mat[r][c] <= '0;
                end
            end
        end else if (i_we && n_row_kept) begin
            r_mat[i_row][i_col] <= i_value;
        end
    end

    assign o_rows = r_mat;

endmodule

// ===== rtl/apvt_row_lane.sv =====
// One output row: products, pair sums and full dot product over three stages.
module apvt_row_lane (
    input  logic                  i_clk,
    input  apvt_pkg::t_stage_en   i_en,
    input  apvt_pkg::t_row_vec    i_entries,
    input  apvt_pkg::t_word       i_x,
    input  apvt_pkg::t_word       i_y,
    input  apvt_pkg::t_word       i_z,
    input  logic                  i_is_point,
    output apvt_pkg::t_sum        o_sum
);

    apvt_pkg::t_prod r_prod_x;
    apvt_pkg::t_prod r_prod_y;
    apvt_pkg::t_prod r_prod_z;
    apvt_pkg::t_prod r_wterm;
    apvt_pkg::t_pair r_pair_a;
    apvt_pkg::t_pair r_pair_b;
    apvt_pkg::t_sum  r_sum;
    apvt_pkg::t_prod n_wterm;

    // w is one in fixed point, so the last column term is the entry shifted up
    assign n_wterm = i_is_point
                   ? (apvt_pkg::t_prod'(i_entries[3]) <<< apvt_pkg::FRAC_BITS)
                   : '0;

    always_ff @(posedge i_clk) begin
        if (i_en.en_mul) begin
            r_prod_x <= apvt_pkg::t_prod'(i_entries[0]) * apvt_pkg::t_prod'(i_x);
            r_prod_y <= apvt_pkg::t_prod'(i_entries[1]) * apvt_pkg::t_prod'(i_y);
            r_prod_z <= apvt_pkg::t_prod'(i_entries[2]) * apvt_pkg::t_prod'(i_z);
            r_wterm  <= n_wterm;
        end
        if (i_en.en_pair) begin
            r_pair_a <= apvt_pkg::t_pair'(r_prod_x) + apvt_pkg::t_pair'(r_prod_y);
            r_pair_b <= apvt_pkg::t_pair'(r_prod_z) + apvt_pkg::t_pair'(r_wterm);
        end
        if (i_en.en_sum) begin
            r_sum <= apvt_pkg::t_sum'(r_pair_a) + apvt_pkg::t_sum'(r_pair_b);
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== rtl/affine_point_vector_transform.sv =====
// Top level: stream ports, pipeline control, saturation and output register.
//
// Slave side takes load and transform beats; s_axis_tuser[0] is the operation
// (0 load, 1 transform). A load writes one Q16.16 entry of the 4x4 matrix's top three rows at
// the accepting edge and gives no result. A transform beat gives one master
// beat holding the first three rows' dot products with (x, y, z, w), where w
// is one for a point and zero for a vector, each floored back to Q16.16 and
// saturated; overflow marks any saturated coordinate.
// Throughput is one beat per cycle while the output is not stalled. A transform
// is multiplied at the accepting edge, then goes through pair add, final add,
// and saturate into the output register for the master side. Loads take
// effect for the very next transform, since products are formed as it enters.
// Each stage holds its valid bit and moves on when the stage after it is free,
// so bubbles close up behind a waiting output beat: the slave side stays ready
// while any stage is free, letting up to three more transforms in, then drops
// until the receiver takes the output beat.
// Synchronous reset clears the matrix to zero and drops all valid bits.
module affine_point_vector_transform (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row, column, entry_value, coord_x, coord_y, coord_z, zero pad
    input  logic [apvt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // operation, is_point
    input  logic [apvt_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // result_x, result_y, result_z
    output logic [apvt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // result_is_point, overflow
    output logic [apvt_pkg::OUT_TUSER_W-1:0]    m_axis_tuser
);

    typedef struct packed {
        apvt_pkg::t_word value;
        logic            ovf;
    } t_sat;

    function automatic t_sat sat_word(input apvt_pkg::t_sum s);
        logic [apvt_pkg::SUM_W-apvt_pkg::DATA_WIDTH-apvt_pkg::FRAC_BITS:0] hi;
        t_sat res;
        hi = s[apvt_pkg::SUM_W-1:apvt_pkg::DATA_WIDTH-1+apvt_pkg::FRAC_BITS];
        if ((&hi) || !(|hi)) begin
            res.value = s[apvt_pkg::DATA_WIDTH-1+apvt_pkg::FRAC_BITS:apvt_pkg::FRAC_BITS];
            res.ovf   = 1'b0;
        end else begin
            res.value = s[apvt_pkg::SUM_W-1]
                      ? {1'b1, {(apvt_pkg::DATA_WIDTH-1){1'b0}}}
                      : {1'b0, {(apvt_pkg::DATA_WIDTH-1){1'b1}}};
            res.ovf   = 1'b1;
        end
        return res;
    endfunction

    apvt_pkg::t_op       n_op;
    logic                n_accept;
    logic                n_rdy1;
    logic                n_rdy2;
    logic                n_rdy3;
    logic                n_rdy_out;
    apvt_pkg::t_stage_en n_en;
    apvt_pkg::t_matrix   n_rows;
    apvt_pkg::t_sum      n_sum [apvt_pkg::OUT_ROWS];
    t_sat                n_sat [apvt_pkg::OUT_ROWS];
    logic                n_ovf;

    logic r_v1, r_v2, r_v3, r_vo;
    logic r_pt1, r_pt2, r_pt3;
    logic [apvt_pkg::OUT_TDATA_W-1:0] r_out_data;
    logic r_out_pt;
    logic r_out_ovf;

    assign n_op     = apvt_pkg::t_op'(s_axis_tuser[apvt_pkg::TU_OP]);
    assign n_accept = s_axis_tvalid && s_axis_tready;

    // Ready chain: a stage may load when empty or when its contents move on
    assign n_rdy_out = !r_vo || m_axis_tready;
    assign n_rdy3    = !r_v3 || n_rdy_out;
    assign n_rdy2    = !r_v2 || n_rdy3;
    assign n_rdy1    = !r_v1 || n_rdy2;

    assign n_en.en_mul  = n_rdy1;
    assign n_en.en_pair = n_rdy2;
    assign n_en.en_sum  = n_rdy3;

    assign s_axis_tready = n_rdy1;

    apvt_matrix u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (n_accept && (n_op == apvt_pkg::OP_LOAD)),
        .i_row   (s_axis_tdata[apvt_pkg::ROW_LSB +: apvt_pkg::IDX_W]),
        .i_col   (s_axis_tdata[apvt_pkg::COL_LSB +: apvt_pkg::IDX_W]),
        .i_value (s_axis_tdata[apvt_pkg::ENTRY_LSB +: apvt_pkg::DATA_WIDTH]),
        .o_rows  (n_rows)
    );

    for (genvar g = 0; g < apvt_pkg::OUT_ROWS; g++) begin : g_lane
        apvt_row_lane u_lane (
            .i_clk      (i_clk),
            .i_en       (n_en),
            .i_entries  (n_rows[g]),
            .i_x        (s_axis_tdata[apvt_pkg::X_LSB +: apvt_pkg::DATA_WIDTH]),
            .i_y        (s_axis_tdata[apvt_pkg::Y_LSB +: apvt_pkg::DATA_WIDTH]),
            .i_z        (s_axis_tdata[apvt_pkg::Z_LSB +: apvt_pkg::DATA_WIDTH]),
            .i_is_point (s_axis_tuser[apvt_pkg::TU_IS_POINT]),
            .o_sum      (n_sum[g])
        );
    end

    always_comb begin
        n_ovf = 1'b0;
        for (int r = 0; r < apvt_pkg::OUT_ROWS; r++) begin
            n_sat[r] = sat_word(n_sum[r]);
            n_ovf    = n_ovf | n_sat[r].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (n_rdy1)    r_v1 <= n_accept && (n_op == apvt_pkg::OP_XFORM);
            if (n_rdy2)    r_v2 <= r_v1;
            if (n_rdy3)    r_v3 <= r_v2;
            if (n_rdy_out) r_vo <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_rdy1) r_pt1 <= s_axis_tuser[apvt_pkg::TU_IS_POINT];
        if (n_rdy2) r_pt2 <= r_pt1;
        if (n_rdy3) r_pt3 <= r_pt2;
        if (n_rdy_out) begin
            for (int r = 0; r < apvt_pkg::OUT_ROWS; r++) begin
                r_out_data[r*apvt_pkg::DATA_WIDTH +: apvt_pkg::DATA_WIDTH] <= n_sat[r].value;
            end
            r_out_pt  <= r_pt3;
            r_out_ovf <= n_ovf;
        end
    end

    assign m_axis_tvalid                     = r_vo;
    assign m_axis_tdata                      = r_out_data;
    assign m_axis_tuser[apvt_pkg::TU_RES_PT] = r_out_pt;
    assign m_axis_tuser[apvt_pkg::TU_OVF]    = r_out_ovf;

    // Accepted transform enters the first stage; a load never does
    a_xform_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_accept |=> (r_v1 == ($past(n_op) == apvt_pkg::OP_XFORM)))
        else $error("stage one valid does not follow accepted beat kind");

    // Blocked first stage keeps its item and its mark
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !n_rdy1) |=> (r_v1 && $stable(r_pt1)))
        else $error("stalled stage one lost its item");

    // Last stage item moves into the output register when it is free
    a_stage3_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && n_rdy_out) |=> r_vo)
        else $error("stage three item dropped on the way out");

    // Slave side stays open while the output waits if the pipe has room
    a_no_false_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_v1 || !r_v2 || !r_v3) |-> s_axis_tready)
        else $error("input stalled with a free stage");

endmodule

// ===== verif/affine_point_vector_transform_tb.sv =====
// Self-checking testbench for the affine point/vector transform block.
`timescale 1ns / 100ps

module affine_point_vector_transform_tb;
    import apvt_pkg::*;

    localparam int    CYCLE_LIMIT = 200_000;
    localparam t_word Q_ONE       = 32'sh0001_0000;
    localparam t_word WORD_MAX    = 32'sh7FFF_FFFF;
    localparam t_word WORD_MIN    = 32'sh8000_0000;

    typedef logic signed [SUM_W-1:0] t_acc;

    typedef struct {
        t_word x;
        t_word y;
        t_word z;
        logic  is_point;
        logic  overflow;
    } t_xform_result;

    // Tracks the matrix and the transform results still owed by the block
    class xform_scoreboard;
        t_word         matrix [MAT_DIM*MAT_DIM];
        t_xform_result owed_results [$];
        int            errors;
        int            loads;
        int            xforms;
        int            saturated;

        function new();
            foreach (matrix[i]) matrix[i] = '0;
            errors    = 0;
            loads     = 0;
            xforms    = 0;
            saturated = 0;
        endfunction

        function t_word floor_sat(input t_acc acc, inout logic ovf);
            t_acc q;
            q = acc >>> FRAC_BITS;
            if (q > t_acc'(WORD_MAX)) begin
                ovf = 1'b1;
                return WORD_MAX;
            end
            if (q < t_acc'(WORD_MIN)) begin
                ovf = 1'b1;
                return WORD_MIN;
            end
            return t_word'(q);
        endfunction

        function t_xform_result transform_point(t_word x, t_word y, t_word z, logic pt);
            t_xform_result res;
            t_word         coord [MAT_DIM];
            t_word         row_out [OUT_ROWS];
            t_acc          acc;
            t_acc          ea;
            t_acc          eb;
            logic          ovf;
            coord[0] = x;
            coord[1] = y;
            coord[2] = z;
            coord[3] = pt ? Q_ONE : '0;
            ovf = 1'b0;
            for (int r = 0; r < OUT_ROWS; r++) begin
                acc = '0;
                for (int c = 0; c < MAT_DIM; c++) begin
                    ea  = matrix[r*MAT_DIM + c];
                    eb  = coord[c];
                    acc = acc + ea * eb;
                end
                row_out[r] = floor_sat(acc, ovf);
            end
            res.x        = row_out[0];
            res.y        = row_out[1];
            res.z        = row_out[2];
            res.is_point = pt;
            res.overflow = ovf;
            return res;
        endfunction

        function void note_beat(t_op op, t_idx row, t_idx col, t_word entry,
                                t_word x, t_word y, t_word z, logic pt);
            t_xform_result res;
            if (op == OP_LOAD) begin
                matrix[row*MAT_DIM + col] = entry;
                loads++;
            end else begin
                res = transform_point(x, y, z, pt);
                if (res.overflow) saturated++;
                owed_results.push_back(res);
                xforms++;
            end
        endfunction

        function void check_beat(logic [OUT_TDATA_W-1:0] data,
                                 logic [OUT_TUSER_W-1:0] user);
            t_xform_result want;
            t_word         got_x;
            t_word         got_y;
            t_word         got_z;
            got_x = data[0 +: DATA_WIDTH];
            got_y = data[DATA_WIDTH +: DATA_WIDTH];
            got_z = data[2*DATA_WIDTH +: DATA_WIDTH];
            if (owed_results.size() == 0) begin
                $error("unexpected result beat: x %0d y %0d z %0d", got_x, got_y, got_z);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            if (got_x !== want.x) begin
                $error("result_x: expected %0d, got %0d", want.x, got_x);
                errors++;
            end
            if (got_y !== want.y) begin
                $error("result_y: expected %0d, got %0d", want.y, got_y);
                errors++;
            end
            if (got_z !== want.z) begin
                $error("result_z: expected %0d, got %0d", want.z, got_z);
                errors++;
            end
            if (user[TU_RES_PT] !== want.is_point) begin
                $error("result_is_point: expected %0b, got %0b", want.is_point,
                       user[TU_RES_PT]);
                errors++;
            end
            if (user[TU_OVF] !== want.overflow) begin
                $error("overflow: expected %0b, got %0b", want.overflow, user[TU_OVF]);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // row, column, entry, x, y, z, zero pad
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;   // operation, is_point
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;        // result_x, result_y, result_z
    logic [OUT_TUSER_W-1:0] m_axis_tuser;        // result_is_point, overflow

    xform_scoreboard sb = new();
    int              cycles = 0;
    int              burst_left = 0;
    int              items_sent = 0;
    logic [15:0]     stall_cnt = '0;
    logic [1:0]      stall_mode = '0;

    affine_point_vector_transform dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results owed", cycles, sb.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: switch between stall styles whenever the low seven bits of stall_cnt are zero
    always @(posedge i_clk) begin
        stall_cnt <= stall_cnt + 16'd1;
        if (stall_cnt[6:0] == 7'd0) stall_mode <= 2'($urandom_range(3));
        case (stall_mode)
            2'd0:    m_axis_tready <= 1'b1;
            2'd1:    m_axis_tready <= ($urandom_range(3) != 0);
            2'd2:    m_axis_tready <= ($urandom_range(3) == 0);
            default: m_axis_tready <= (stall_cnt[3:0] < 4'd9);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tuser);
    end

    function automatic t_word pick_value(int small_weight);
        int sel;
        sel = $urandom_range(99);
        if (sel < small_weight)
            return t_word'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
        if (sel < small_weight + 12) begin
            case ($urandom_range(6))
                0:       return WORD_MAX;
                1:       return WORD_MIN;
                2:       return '0;
                3:       return -32'sd1;
                4:       return 32'sd1;
                5:       return Q_ONE;
                default: return -Q_ONE;
            endcase
        end
        return t_word'($urandom);
    endfunction

    // Drive one beat, pacing the sender in bursts, and hold until accepted
    task automatic send_beat(t_op op, t_idx row, t_idx col, t_word entry,
                             t_word x, t_word y, t_word z, logic pt);
        logic [IN_TDATA_W-1:0] d;
        logic [IN_TUSER_W-1:0] u;
        int                    gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 12);
        end
        burst_left--;
        d = '0;
        d[ROW_LSB +: IDX_W]        = row;
        d[COL_LSB +: IDX_W]        = col;
        d[ENTRY_LSB +: DATA_WIDTH] = entry;
        d[X_LSB +: DATA_WIDTH]     = x;
        d[Y_LSB +: DATA_WIDTH]     = y;
        d[Z_LSB +: DATA_WIDTH]     = z;
        u = '0;
        u[TU_OP]       = op;
        u[TU_IS_POINT] = pt;
        s_axis_tdata  <= d;
        s_axis_tuser  <= u;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_beat(op, row, col, entry, x, y, z, pt);
        items_sent++;
    endtask

    task automatic load_entry(t_idx row, t_idx col, t_word entry);
        send_beat(OP_LOAD, row, col, entry, t_word'($urandom), t_word'($urandom),
                  t_word'($urandom), 1'($urandom));
    endtask

    task automatic xform(t_word x, t_word y, t_word z, logic pt);
        send_beat(OP_XFORM, 2'($urandom), 2'($urandom), t_word'($urandom), x, y, z, pt);
    endtask

    initial begin
        int n_load;
        int n_xform;
        int mat_weight;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: cleared matrix, identity plus translation, saturation, floor rounding
        xform(WORD_MAX, WORD_MIN, -32'sd1, 1'b1);
        load_entry(2'd0, 2'd0, Q_ONE);
        load_entry(2'd1, 2'd1, Q_ONE);
        load_entry(2'd2, 2'd2, Q_ONE);
        load_entry(2'd0, 2'd3, 32'sh0002_8000);
        load_entry(2'd1, 2'd3, -32'sh0003_0000);
        load_entry(2'd2, 2'd3, WORD_MAX);
        xform(Q_ONE, 32'sh0002_0000, 32'sh0003_0000, 1'b1);
        xform(Q_ONE, 32'sh0002_0000, 32'sh0003_0000, 1'b0);
        // fourth row writes are dropped by the block and never feed an output
        load_entry(2'd3, 2'd3, -32'sd1);
        load_entry(2'd3, 2'd0, WORD_MAX);
        xform(WORD_MAX, WORD_MIN, -32'sd1, 1'b1);
        load_entry(2'd0, 2'd0, WORD_MIN);
        xform(WORD_MIN, '0, '0, 1'b0);
        xform(WORD_MAX, '0, '0, 1'b0);
        load_entry(2'd1, 2'd1, 32'sd1);
        xform('0, -32'sd1, '0, 1'b0);
        load_entry(2'd2, 2'd3, WORD_MIN);
        xform('0, '0, WORD_MIN, 1'b1);
        xform(-32'sd1, 32'sd1, WORD_MAX, 1'b0);

        // Random: mostly matrix updates followed by runs of transforms
        while (items_sent < 670) begin
            if ($urandom_range(9) < 7) begin
                mat_weight = ($urandom_range(3) == 0) ? 40 : 85;
                n_load  = $urandom_range(1, 8);
                n_xform = $urandom_range(1, 10);
                repeat (n_load)
                    load_entry(2'($urandom), 2'($urandom), pick_value(mat_weight));
                repeat (n_xform)
                    xform(pick_value(70), pick_value(70), pick_value(70), 1'($urandom));
            end else if ($urandom_range(1)) begin
                load_entry(2'($urandom), 2'($urandom), pick_value(20));
            end else begin
                xform(pick_value(20), pick_value(20), pick_value(20), 1'($urandom));
            end
        end
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        $display("sent %0d loads and %0d transforms with bursty input and stalled output,",
                 sb.loads, sb.xforms);
        $display("%0d transforms expected to saturate; %0d mismatches", sb.saturated,
                 sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
